FILE: design/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg
// Shared widths, reset values, register indexes, types and state encoding
// for the moisture average and percentage mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package mep_pkg;

    // Converter sample width
    localparam int SAMPLE_BITS = 12;
    // Percentage field width (0..100)
    localparam int PCT_BITS    = 7;
    // Configuration register index width
    localparam int CFG_IDX_W   = 1;
    // 9*avg + sample stays below 10 * 2^SAMPLE_BITS
    localparam int AVG_NUM_W   = SAMPLE_BITS + 4;
    // (dry - clamped) * 100 stays below 2^(SAMPLE_BITS+7)
    localparam int PCT_NUM_W   = SAMPLE_BITS + 7;
    // Step counter of the serial divider
    localparam int STEP_W      = $clog2(SAMPLE_BITS + 1);

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [PCT_BITS-1:0]    t_pct;
    typedef logic [STEP_W-1:0]      t_step;

    localparam t_sample DRY_RESET   = t_sample'(3400);
    localparam t_sample WET_RESET   = t_sample'(1200);
    localparam t_sample AVG_DIVISOR = t_sample'(10);
    localparam t_step   AVG_STEPS   = t_step'(SAMPLE_BITS);
    localparam t_step   PCT_STEPS   = t_step'(PCT_BITS);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DRY = 1'b0,
        REG_WET = 1'b1
    } t_cfg_idx;

    // Item sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_CLAMP,
        ST_SCALE,
        ST_PCT,
        ST_DONE
    } t_state;

    // Request to the serial divider: the partial remainder starts at rem0
    // and the dividend bits still to bring down sit left-aligned in bits.
    typedef struct packed {
        logic    start;
        t_sample rem0;
        t_sample bits;
        t_step   steps;
        t_sample divisor;
    } t_div_req;

    // Divider response: done pulses once, quotient sits in the low bits
    typedef struct packed {
        logic    done;
        t_sample quot;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: design/mep_if.sv
// ----------------------------------------------------------------------------
// mep_if
// Valid/ready channels of the mapper: input samples, results and
// configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mep_in_if;
    logic              valid;
    logic              ready;
    mep_pkg::t_sample  sample;

    modport source (output valid, output sample, input  ready);
    modport sink   (input  valid, input  sample, output ready);
endinterface

interface mep_out_if;
    logic              valid;
    logic              ready;
    mep_pkg::t_pct     percent;
    mep_pkg::t_sample  filtered;
    logic              bad_calibration;

    modport source (output valid, output percent, output filtered,
                    output bad_calibration, input ready);
    modport sink   (input  valid, input  percent, input  filtered,
                    input  bad_calibration, output ready);
endinterface

interface mep_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mep_pkg::CFG_IDX_W-1:0]    index;
    mep_pkg::t_sample                 data;

    modport source (output valid, output index, output data, input  ready);
    modport sink   (input  valid, input  index, input  data, output ready);
endinterface

`default_nettype wire

FILE: design/mep_serdiv.sv
// ----------------------------------------------------------------------------
// mep_serdiv
// Bit-serial restoring divider. Brings down one dividend bit per cycle,
// compares against the divisor and shifts one quotient bit in.
// ----------------------------------------------------------------------------
`default_nettype none

module mep_serdiv (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mep_pkg::t_div_req i_req,
    output mep_pkg::t_div_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    mep_pkg::t_step    r_cnt;
    mep_pkg::t_sample  r_rem;
    mep_pkg::t_sample  r_sh;
    mep_pkg::t_sample  r_div;

    logic [mep_pkg::SAMPLE_BITS:0] w_trial;
    logic [mep_pkg::SAMPLE_BITS:0] w_diff;
    logic                          w_ge;

    // Bring down the next dividend bit and try the subtraction
    assign w_trial = {r_rem, r_sh[mep_pkg::SAMPLE_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    // Control: busy for the requested number of steps, then one done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == mep_pkg::t_step'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - mep_pkg::t_step'(1);
                if (r_cnt == mep_pkg::t_step'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: remainder and the shared dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem0;
            r_sh  <= i_req.bits;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[mep_pkg::SAMPLE_BITS-1:0]
                          : w_trial[mep_pkg::SAMPLE_BITS-1:0];
            r_sh  <= {r_sh[mep_pkg::SAMPLE_BITS-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_sh;

endmodule

`default_nettype wire

FILE: design/moisture_ema_percent_mapper_core.sv
// ----------------------------------------------------------------------------
// moisture_ema_percent_mapper_core
// Running average of moisture probe samples mapped to a 0..100 percentage
// between the wet and dry calibration points.
// ----------------------------------------------------------------------------
// Each accepted sample updates the running average (loaded directly when the
// stored average is zero, else (9*avg + sample)/10) and yields one result:
// the average, the percentage (dry - clamped)*100/(dry - wet) and a flag when
// dry is not above wet (percent then reads 0). One item is worked at a time;
// both divisions run on a single bit-serial divider, one quotient bit per
// cycle. The average division is skipped when the stored average is zero, and
// the percentage division is skipped when the calibration is bad. A finished
// result waits in an output register, so the next sample is taken while it
// is still unread.
// Configuration writes are always ready and must land only while idle.
`default_nettype none

module moisture_ema_percent_mapper_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mep_cfg_if.sink    i_cfg,
    mep_in_if.sink     i_in,
    mep_out_if.source  o_out
);

    mep_pkg::t_state   r_state;
    mep_pkg::t_state   n_state;

    mep_pkg::t_sample  r_dry;
    mep_pkg::t_sample  r_wet;
    mep_pkg::t_sample  r_avg;
    mep_pkg::t_sample  r_diff;
    logic              r_bad;
    mep_pkg::t_pct     r_pct;

    logic              r_out_valid;
    mep_pkg::t_pct     r_out_pct;
    mep_pkg::t_sample  r_out_filt;
    logic              r_out_bad;

    mep_pkg::t_div_req w_req;
    mep_pkg::t_div_rsp w_rsp;

    logic                            w_in_beat;
    logic                            w_out_load;
    logic [mep_pkg::AVG_NUM_W-1:0]   w_avg_num;
    logic [mep_pkg::PCT_NUM_W-1:0]   w_pct_num;
    mep_pkg::t_sample                w_clamp_hi;
    mep_pkg::t_sample                w_clamp;
    logic                            w_bad_cal;

    assign w_in_beat = i_in.valid && i_in.ready;

    // 9*avg + sample as shift and add
    assign w_avg_num = ({4'b0, r_avg} << 3) + {4'b0, r_avg} + {4'b0, i_in.sample};

    // (dry - clamped) * 100 as 64 + 32 + 4
    assign w_pct_num = ({7'b0, r_diff} << 6) + ({7'b0, r_diff} << 5)
                     + ({7'b0, r_diff} << 2);

    // Clamp the average into [wet, dry]
    assign w_bad_cal  = (r_dry <= r_wet);
    assign w_clamp_hi = (r_avg > r_dry) ? r_dry : r_avg;
    assign w_clamp    = (w_clamp_hi < r_wet) ? r_wet : w_clamp_hi;

    mep_serdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mep_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, divider requests and output load
    always_comb begin
        n_state     = r_state;
        w_out_load  = 1'b0;
        w_req.start   = 1'b0;
        w_req.rem0    = '0;
        w_req.bits    = '0;
        w_req.steps   = mep_pkg::AVG_STEPS;
        w_req.divisor = mep_pkg::AVG_DIVISOR;
        unique case (r_state)
            mep_pkg::ST_IDLE: begin
                w_req.rem0 = mep_pkg::t_sample'(w_avg_num[mep_pkg::AVG_NUM_W-1:
                                                          mep_pkg::SAMPLE_BITS]);
                w_req.bits = w_avg_num[mep_pkg::SAMPLE_BITS-1:0];
                if (w_in_beat) begin
                    if (r_avg == '0) begin
                        n_state = mep_pkg::ST_CLAMP;
                    end else begin
                        w_req.start = 1'b1;
                        n_state     = mep_pkg::ST_AVG;
                    end
                end
            end
            mep_pkg::ST_AVG: begin
                if (w_rsp.done) begin
                    n_state = mep_pkg::ST_CLAMP;
                end
            end
            mep_pkg::ST_CLAMP: begin
                n_state = w_bad_cal ? mep_pkg::ST_DONE : mep_pkg::ST_SCALE;
            end
            mep_pkg::ST_SCALE: begin
                w_req.start   = 1'b1;
                w_req.rem0    = w_pct_num[mep_pkg::PCT_NUM_W-1:mep_pkg::PCT_BITS];
                w_req.bits    = {w_pct_num[mep_pkg::PCT_BITS-1:0],
                                 {(mep_pkg::SAMPLE_BITS-mep_pkg::PCT_BITS){1'b0}}};
                w_req.steps   = mep_pkg::PCT_STEPS;
                w_req.divisor = r_dry - r_wet;
                n_state       = mep_pkg::ST_PCT;
            end
            mep_pkg::ST_PCT: begin
                if (w_rsp.done) begin
                    n_state = mep_pkg::ST_DONE;
                end
            end
            mep_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    w_out_load = 1'b1;
                    n_state    = mep_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mep_pkg::ST_IDLE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry <= mep_pkg::DRY_RESET;
            r_wet <= mep_pkg::WET_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (mep_pkg::t_cfg_idx'(i_cfg.index))
                mep_pkg::REG_DRY: r_dry <= i_cfg.data;
                mep_pkg::REG_WET: r_wet <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Running average
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= '0;
        end else if (r_state == mep_pkg::ST_IDLE && w_in_beat && r_avg == '0) begin
            r_avg <= i_in.sample;
        end else if (r_state == mep_pkg::ST_AVG && w_rsp.done) begin
            r_avg <= w_rsp.quot;
        end
    end

    // Clamped distance from the dry point, flag and percentage
    always_ff @(posedge i_clk) begin
        if (r_state == mep_pkg::ST_CLAMP) begin
            r_diff <= r_dry - w_clamp;
            r_bad  <= w_bad_cal;
            r_pct  <= '0;
        end else if (r_state == mep_pkg::ST_PCT && w_rsp.done) begin
            r_pct <= w_rsp.quot[mep_pkg::PCT_BITS-1:0];
        end
    end

    // Output register: hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_pct  <= r_pct;
            r_out_filt <= r_avg;
            r_out_bad  <= r_bad;
        end
    end

    assign i_cfg.ready           = 1'b1;
    assign i_in.ready            = (r_state == mep_pkg::ST_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.percent         = r_out_pct;
    assign o_out.filtered        = r_out_filt;
    assign o_out.bad_calibration = r_out_bad;

endmodule

`default_nettype wire

FILE: tb/tb_moisture_ema_percent_mapper_core.sv
// ----------------------------------------------------------------------------
// tb_moisture_ema_percent_mapper_core
// Self-checking bench for the moisture averager and percentage mapper: a
// short table of directed samples and register writes, then random sample
// bursts under several calibrations; each result is checked against a
// typed table row or an in-bench model of running average and percentage.
// ----------------------------------------------------------------------------
module tb_moisture_ema_percent_mapper_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HALF_PERIOD  = 10;
    localparam int          RESET_CYCLES = 9;
    localparam int          SETTLE       = 40;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          HOLD_AT      = 700;
    localparam int          PHASE_ITEMS  = 300;
    localparam int          NUM_PHASES   = 6;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int unsigned OLD_WEIGHT   = 9;
    localparam int unsigned AVG_DIV      = 10;
    localparam int unsigned FULL_SCALE   = 100;
    localparam int unsigned SAMPLE_MAX   = (1 << mep_pkg::SAMPLE_BITS) - 1;

    typedef struct packed {
        mep_pkg::t_pct    pct;
        mep_pkg::t_sample filt;
        logic             bad;
    } t_moist_res;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        mep_pkg::t_cfg_idx idx;
        mep_pkg::t_sample  value;
        logic              typed;
        mep_pkg::t_pct     pct;
        mep_pkg::t_sample  filt;
        logic              bad;
    } t_row;

    localparam int N_DIRECTED = 23;

    // Directed rows: after reset the average loads, decays to zero and
    // reloads; then extreme, inverted, equal and one-count calibrations
    t_row directed_plan [0:N_DIRECTED-1] = '{
        '{ROW_SAMPLE, mep_pkg::REG_DRY, 12'd0,    1'b1, 7'd100, 12'd0,    1'b0},
        '{ROW_SAMPLE, mep_pkg::REG_DRY, 12'd1,    1'b1, 7'd100, 12'd1,    1'b0},
        '{ROW_SAMPLE, mep_pkg::REG_DRY, 12'd0,    1'b1, 7'd100, 12'd0,    1'b0},
        '{ROW_SAMPLE, mep_pkg::REG_DRY, 12'd4095, 1'b1, 7'd0,   12'd4095, 1'b0},
        '{ROW_SAMPLE, mep_pkg::REG_DRY, 12'd4095, 1'b1, 7'd0,   12'd4095, 1'b0},
        '{ROW_SAMPLE, mep_pkg::REG_DRY, 12'd0,    1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_SAMPLE, mep_pkg::REG_DRY, 12'd2300, 1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_SAMPLE, mep_pkg::REG_DRY, 12'd1200, 1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_CFG,    mep_pkg::REG_DRY, 12'd4095, 1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_CFG,    mep_pkg::REG_WET, 12'd0,    1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_SAMPLE, mep_pkg::REG_DRY, 12'd4095, 1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_SAMPLE, mep_pkg::REG_DRY, 12'd0,    1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_CFG,    mep_pkg::REG_DRY, 12'd0,    1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_CFG,    mep_pkg::REG_WET, 12'd4095, 1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_SAMPLE, mep_pkg::REG_DRY, 12'd2048, 1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_SAMPLE, mep_pkg::REG_DRY, 12'd4095, 1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_CFG,    mep_pkg::REG_DRY, 12'd2000, 1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_CFG,    mep_pkg::REG_WET, 12'd2000, 1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_SAMPLE, mep_pkg::REG_DRY, 12'd2000, 1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_CFG,    mep_pkg::REG_DRY, 12'd1201, 1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_CFG,    mep_pkg::REG_WET, 12'd1200, 1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_SAMPLE, mep_pkg::REG_DRY, 12'd1200, 1'b0, 7'd0,   12'd0,    1'b0},
        '{ROW_SAMPLE, mep_pkg::REG_DRY, 12'd4095, 1'b0, 7'd0,   12'd0,    1'b0}
    };

    logic i_clk;
    logic i_rst_n;

    mep_in_if  in_ch ();
    mep_out_if out_ch ();
    mep_cfg_if cfg_ch ();

    moisture_ema_percent_mapper_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Model state: running average and calibration points
    mep_pkg::t_sample avg_state = '0;
    mep_pkg::t_sample dry_state = mep_pkg::DRY_RESET;
    mep_pkg::t_sample wet_state = mep_pkg::WET_RESET;

    t_moist_res pending_results [$];

    // Typed expectation riding along with the sample beat being offered
    logic       drv_typed = 1'b0;
    t_moist_res drv_exp   = '0;

    int n_errors    = 0;
    int n_items     = 0;
    int n_results   = 0;
    int n_writes    = 0;
    int n_bad       = 0;
    int n_loads     = 0;
    int n_taken     = 0;
    int cycle_count = 0;

    // Free-running clock
    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("FAIL moisture_ema_percent_mapper_core");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    // Advance the running average and map it onto the percentage scale
    function automatic t_moist_res average_and_scale(input mep_pkg::t_sample s);
        t_moist_res  r;
        int unsigned a;
        int unsigned dry;
        int unsigned wet;
        int unsigned c;
        a   = avg_state;
        dry = dry_state;
        wet = wet_state;
        if (a == 0) begin
            a = s;
            n_loads++;
        end else begin
            a = (a * OLD_WEIGHT + s) / AVG_DIV;
        end
        avg_state = mep_pkg::t_sample'(a);
        r.filt = avg_state;
        r.pct  = '0;
        r.bad  = 1'b0;
        if (dry <= wet) begin
            r.bad = 1'b1;
        end else begin
            c = avg_state;
            if (c > dry) c = dry;
            if (c < wet) c = wet;
            r.pct = mep_pkg::t_pct'(((dry - c) * FULL_SCALE) / (dry - wet));
        end
        return r;
    endfunction

    // Check result beats, track register writes, predict sample beats
    always @(posedge i_clk) begin
        t_moist_res want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (out_ch.bad_calibration) n_bad++;
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with nothing pending, filtered",
                                    out_ch.filtered, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.percent !== want.pct)
                        report_mismatch("percent", out_ch.percent, want.pct);
                    if (out_ch.filtered !== want.filt)
                        report_mismatch("filtered", out_ch.filtered, want.filt);
                    if (out_ch.bad_calibration !== want.bad)
                        report_mismatch("bad_calibration", out_ch.bad_calibration,
                                        want.bad);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                n_writes++;
                if (mep_pkg::t_cfg_idx'(cfg_ch.index) == mep_pkg::REG_DRY)
                    dry_state = cfg_ch.data;
                else
                    wet_state = cfg_ch.data;
            end
            if (in_ch.valid && in_ch.ready) begin
                n_items++;
                want = average_and_scale(in_ch.sample);
                pending_results.push_back(drv_typed ? drv_exp : want);
            end
        end
    end

    // Random wait per beat, with periodic stretches of back-to-back beats
    function automatic int draw_gap(input int count, input int period);
        if ((count / period) % 4 == 3) return 0;
        return $urandom_range(0, 17);
    endfunction

    // Result side: random stalls plus one long hold-off to back up the block
    initial begin
        int  gap;
        bit  held;
        held = 1'b0;
        out_ch.ready = 1'b0;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            gap = draw_gap(n_taken, 110);
            if (!held && n_taken >= HOLD_AT) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            @(negedge i_clk);
            if (gap != 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            n_taken++;
        end
    end

    // Offer one sample beat after a gap and hold it until taken
    task automatic send_sample(input mep_pkg::t_sample s, input int gap,
                               input logic typed, input t_moist_res exp_res);
        @(negedge i_clk);
        if (gap != 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid  = 1'b1;
        in_ch.sample = s;
        drv_typed    = typed;
        drv_exp      = exp_res;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drop the sample channel and let every result drain
    task automatic await_idle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        drv_typed   = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input mep_pkg::t_cfg_idx idx,
                             input mep_pkg::t_sample value);
        await_idle();
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic mep_pkg::t_sample clip_sample(input int v);
        if (v < 0) return '0;
        if (v > int'(SAMPLE_MAX)) return mep_pkg::t_sample'(SAMPLE_MAX);
        return mep_pkg::t_sample'(v);
    endfunction

    // Main stimulus
    initial begin
        t_moist_res       exp_res;
        mep_pkg::t_sample dry_w;
        mep_pkg::t_sample wet_w;
        mep_pkg::t_sample held_value;
        int               phase_count;
        int               burst_len;
        int               burst_kind;
        int               k;

        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table
        for (int r = 0; r < N_DIRECTED; r++) begin
            if (directed_plan[r].kind == ROW_CFG) begin
                write_reg(directed_plan[r].idx, directed_plan[r].value);
            end else begin
                exp_res.pct  = directed_plan[r].pct;
                exp_res.filt = directed_plan[r].filt;
                exp_res.bad  = directed_plan[r].bad;
                send_sample(directed_plan[r].value, $urandom_range(0, 3),
                            directed_plan[r].typed, exp_res);
            end
        end

        // Random phases, each under its own calibration
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    dry_w = mep_pkg::DRY_RESET;
                    wet_w = mep_pkg::WET_RESET;
                end
                1, 4: begin
                    wet_w = mep_pkg::t_sample'($urandom_range(0, SAMPLE_MAX - 1));
                    dry_w = mep_pkg::t_sample'($urandom_range(int'(wet_w) + 1,
                                                              SAMPLE_MAX));
                end
                2: begin
                    dry_w = mep_pkg::t_sample'(SAMPLE_MAX);
                    wet_w = '0;
                end
                3: begin
                    dry_w = mep_pkg::t_sample'($urandom_range(0, SAMPLE_MAX));
                    wet_w = mep_pkg::t_sample'($urandom_range(0, SAMPLE_MAX));
                end
                default: begin
                    wet_w = mep_pkg::t_sample'($urandom_range(0, SAMPLE_MAX - 20));
                    dry_w = mep_pkg::t_sample'(int'(wet_w) + $urandom_range(1, 20));
                end
            endcase
            write_reg(mep_pkg::REG_DRY, dry_w);
            write_reg(mep_pkg::REG_WET, wet_w);

            phase_count = 0;
            while (phase_count < PHASE_ITEMS) begin
                burst_kind = $urandom_range(0, 9);
                burst_len  = (burst_kind == 6) ? 90 : $urandom_range(4, 24);
                held_value = mep_pkg::t_sample'($urandom_range(0, SAMPLE_MAX));
                for (int b = 0; b < burst_len && phase_count < PHASE_ITEMS; b++) begin
                    case (burst_kind)
                        4, 5: begin
                            k = $urandom_range(0, 1) ? int'(dry_w) : int'(wet_w);
                            k = k + $urandom_range(0, 8) - 4;
                            held_value = clip_sample(k);
                        end
                        6:       held_value = '0;
                        7:       held_value = mep_pkg::t_sample'($urandom_range(0, 2));
                        8:       held_value = $urandom_range(0, 1)
                                              ? mep_pkg::t_sample'(SAMPLE_MAX) : '0;
                        9:       ;
                        default: held_value = mep_pkg::t_sample'(
                                                  $urandom_range(0, SAMPLE_MAX));
                    endcase
                    send_sample(held_value, draw_gap(n_items, 90), 1'b0, '0);
                    phase_count++;
                end
            end
        end

        // Drain, then let any stray beat show up
        await_idle();
        if (pending_results.size() != 0)
            report_mismatch("results left outstanding", pending_results.size(), 0);

        $display("run covered %0d samples and %0d results over %0d register writes",
                 n_items, n_results, n_writes);
        $display("%0d results flagged bad calibration, %0d averages loaded from zero",
                 n_bad, n_loads);
        if (n_errors == 0) begin
            $display("PASS moisture_ema_percent_mapper_core");
        end else begin
            $display("FAIL moisture_ema_percent_mapper_core");
        end
        $finish;
    end

endmodule
